/* rtl/core/cbc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the cartridge bank controller.
// No dependencies; imported by the top level, its port checker and the simulation files.
package cbc_pkg;

    // Port field widths
    localparam int OP_W       = 3;
    localparam int ADDR_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int S_DATA_W   = 40;   // bus_address, load_index, write_byte
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Widths of the internal registers
    localparam int ROM_BANK_W  = 5;
    localparam int RAM_BANK_W  = 2;
    localparam int ROM_LEN_W   = 17;
    localparam int RAM_LEN_W   = 16;
    // Wide enough for any banked ROM address and any ROM size
    localparam int WIDE_W      = 20;

    // Bus access codes carried in s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_ROM_READ   = 3'd0,
        OP_CTRL_WRITE = 3'd1,
        OP_RAM_READ   = 3'd2,
        OP_RAM_WRITE  = 3'd3,
        OP_ROM_LOAD   = 3'd4
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MBC1_MODE = 2'd0,
        CFG_ROM_BYTES = 2'd1,
        CFG_RAM_BYTES = 2'd2
    } cfg_idx_t;

    // Where a read result comes from
    typedef enum logic [1:0] {
        SRC_OPEN = 2'd0,
        SRC_ROM  = 2'd1,
        SRC_RAM  = 2'd2
    } src_t;

    // Control write regions, decoded from bus_address[15:13]
    typedef enum logic [2:0] {
        REG_RAM_ENABLE = 3'b000,
        REG_ROM_BANK   = 3'b001,
        REG_RAM_BANK_L = 3'b010
    } ctrl_region_t;

    localparam logic [BYTE_W-1:0]     OPEN_BUS       = 8'hFF;
    localparam logic [3:0]            RAM_ENABLE_KEY = 4'hA;
    localparam logic [2:0]            RAM_WINDOW     = 3'b101;  // 0xA000-0xBFFF
    localparam logic [1:0]            ROM_FIXED_WIN  = 2'b00;   // 0x0000-0x3FFF
    localparam logic [1:0]            ROM_BANK_WIN   = 2'b01;   // 0x4000-0x7FFF
    localparam logic [ROM_BANK_W-1:0] ROM_BANK_ONE   = 5'd1;

endpackage

/* rtl/core/cartridge_bank_controller.sv */
`timescale 1ns / 1ps
// Cartridge bank controller: ROM and RAM stores with bank mapping.
// Depends on cbc_pkg.
//
//  Channel   Direction  Handshake           Payload
//  s_        in         s_tvalid/s_tready   s_tuser op, s_tdata address/index/byte
//  m_        out        m_tvalid/m_tready   m_tdata read byte
//  cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One access is taken every cycle while s_tready is high; a read result passes
// through the synchronous memory read and then the output register.
// Writes, bank updates and loads land at the transfer edge, so the next access
// already sees them and no forwarding path is needed.
// After reset the RAM is cleared one byte a cycle with s_tready low;
// configuration writes are taken throughout.
// s_tready is low during the clear and while the read stage holds a result the output cannot take.
module cartridge_bank_controller #(
    parameter int ROM_BYTES = 65536,
    parameter int RAM_BYTES = 32768
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] bus_address, [31:16] load_index, [39:32] write_byte
    input  logic [cbc_pkg::S_DATA_W-1:0]   s_tdata,
    // [2:0] operation
    input  logic [cbc_pkg::OP_W-1:0]       s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] read_data
    output logic [cbc_pkg::BYTE_W-1:0]     m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cbc_pkg::*;

    localparam int ROM_AW = $clog2(ROM_BYTES);
    localparam int RAM_AW = $clog2(RAM_BYTES);

    // Stores
    logic [BYTE_W-1:0] rom_mem [ROM_BYTES];
    logic [BYTE_W-1:0] ram_mem [RAM_BYTES];

    // Configuration registers
    logic                 mbc1_mode_reg;
    logic [ROM_LEN_W-1:0] rom_bytes_reg;
    logic [RAM_LEN_W-1:0] ram_bytes_reg;

    // Mapper state
    logic [ROM_BANK_W-1:0] rom_bank_reg, rom_bank_next;
    logic [RAM_BANK_W-1:0] ram_bank_reg, ram_bank_next;
    logic                  ram_enable_reg, ram_enable_next;

    // RAM clearing sweep
    logic              clear_busy_reg, clear_busy_next;
    logic [RAM_AW-1:0] clear_cnt_reg, clear_cnt_next;

    // Read stage and output register
    logic              p1_valid_reg, p1_valid_next;
    src_t              p1_src_reg, p1_src_next;
    logic [BYTE_W-1:0] rom_q_reg, ram_q_reg;
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_data_reg, m_data_next;

    // Input fields
    op_t               op;
    logic [ADDR_W-1:0] bus_address;
    logic [ADDR_W-1:0] load_index;
    logic [BYTE_W-1:0] write_byte;

    logic accept;
    logic advance;

    // Address decode
    logic [WIDE_W-1:0] rom_banked;
    logic [WIDE_W-1:0] load_wide;
    logic              rom_fixed_hit, rom_bank_hit, load_ok;
    logic [ROM_AW-1:0] rom_rd_addr;
    logic [14:0]       ram_off;
    logic              ram_hit;
    logic [RAM_AW-1:0] ram_addr;

    // Memory ports
    logic              rom_we, rom_re, ram_we, ram_re;
    logic [RAM_AW-1:0] ram_wa;
    logic [BYTE_W-1:0] ram_wd;

    assign op          = op_t'(s_tuser);
    assign bus_address = s_tdata[15:0];
    assign load_index  = s_tdata[31:16];
    assign write_byte  = s_tdata[39:32];

    assign advance   = !m_valid_reg || m_tready;
    assign s_tready  = !clear_busy_reg && (!p1_valid_reg || advance);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Decode ROM, RAM and load addresses
    always_comb begin
        rom_banked    = {1'b0, rom_bank_reg, bus_address[13:0]};
        rom_fixed_hit = (bus_address[15:14] == ROM_FIXED_WIN);
        rom_bank_hit  = (bus_address[15:14] == ROM_BANK_WIN)
                        && (rom_banked < WIDE_W'(rom_bytes_reg))
                        && (rom_banked < WIDE_W'(ROM_BYTES));
        rom_rd_addr   = rom_fixed_hit ? ROM_AW'(bus_address[13:0])
                                      : rom_banked[ROM_AW-1:0];
        load_wide     = WIDE_W'(load_index);
        load_ok       = (load_wide < WIDE_W'(ROM_BYTES));
        ram_off       = {ram_bank_reg, bus_address[12:0]};
        ram_hit       = ram_enable_reg
                        && (bus_address[15:13] == RAM_WINDOW)
                        && ({1'b0, ram_off} < ram_bytes_reg)
                        && ({1'b0, ram_off} < RAM_LEN_W'(RAM_BYTES));
        ram_addr      = ram_off[RAM_AW-1:0];
    end

    // Memory port controls; the clearing sweep owns the RAM write port
    always_comb begin
        rom_we = accept && (op == OP_ROM_LOAD) && load_ok;
        rom_re = accept && (op == OP_ROM_READ);
        ram_re = accept && (op == OP_RAM_READ);
        ram_we = clear_busy_reg || (accept && (op == OP_RAM_WRITE) && ram_hit);
        ram_wa = clear_busy_reg ? clear_cnt_reg : ram_addr;
        ram_wd = clear_busy_reg ? '0 : write_byte;
    end

    // ROM store: load port and read port
    always_ff @(posedge aclk) begin
        if (rom_we) begin
            rom_mem[load_wide[ROM_AW-1:0]] <= write_byte;
        end
        if (rom_re) begin
            rom_q_reg <= rom_mem[rom_rd_addr];
        end
    end

    // RAM store: write port and read port
    always_ff @(posedge aclk) begin
        if (ram_we) begin
            ram_mem[ram_wa] <= ram_wd;
        end
        if (ram_re) begin
            ram_q_reg <= ram_mem[ram_addr];
        end
    end

    // Advance the clearing sweep
    always_comb begin
        clear_busy_next = clear_busy_reg;
        clear_cnt_next  = clear_cnt_reg;
        if (clear_busy_reg) begin
            clear_cnt_next = clear_cnt_reg + 1'b1;
            if (clear_cnt_reg == RAM_AW'(RAM_BYTES - 1)) begin
                clear_busy_next = 1'b0;
            end
        end
    end

    // Update bank registers and RAM enable on control writes in MBC1 mode; 0x6000 and up hold
    always_comb begin
        rom_bank_next   = rom_bank_reg;
        ram_bank_next   = ram_bank_reg;
        ram_enable_next = ram_enable_reg;
        if (accept && (op == OP_CTRL_WRITE) && mbc1_mode_reg) begin
            case (bus_address[15:13])
                REG_RAM_ENABLE: begin
                    ram_enable_next = (write_byte[3:0] == RAM_ENABLE_KEY);
                end
                REG_ROM_BANK: begin
                    rom_bank_next = (write_byte[4:0] == '0) ? ROM_BANK_ONE
                                                            : write_byte[4:0];
                end
                REG_RAM_BANK_L: begin
                    ram_bank_next = write_byte[1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read stage: record where the result comes from
    always_comb begin
        p1_valid_next = p1_valid_reg;
        p1_src_next   = p1_src_reg;
        if (accept) begin
            p1_valid_next = (op == OP_ROM_READ) || (op == OP_RAM_READ);
            if (op == OP_ROM_READ) begin
                p1_src_next = (rom_fixed_hit || rom_bank_hit) ? SRC_ROM : SRC_OPEN;
            end else begin
                p1_src_next = ram_hit ? SRC_RAM : SRC_OPEN;
            end
        end else if (advance) begin
            p1_valid_next = 1'b0;
        end
    end

    // Output register: load from the read stage, drop on transfer
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (p1_valid_reg && advance) begin
            m_valid_next = 1'b1;
            case (p1_src_reg)
                SRC_ROM: m_data_next = rom_q_reg;
                SRC_RAM: m_data_next = ram_q_reg;
                default: m_data_next = OPEN_BUS;
            endcase
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mbc1_mode_reg  <= 1'b0;
            rom_bytes_reg  <= ROM_LEN_W'(32768);
            ram_bytes_reg  <= '0;
            rom_bank_reg   <= ROM_BANK_ONE;
            ram_bank_reg   <= '0;
            ram_enable_reg <= 1'b0;
            clear_busy_reg <= 1'b1;
            clear_cnt_reg  <= '0;
            p1_valid_reg   <= 1'b0;
            p1_src_reg     <= SRC_OPEN;
            m_valid_reg    <= 1'b0;
        end else begin
            rom_bank_reg   <= rom_bank_next;
            ram_bank_reg   <= ram_bank_next;
            ram_enable_reg <= ram_enable_next;
            clear_busy_reg <= clear_busy_next;
            clear_cnt_reg  <= clear_cnt_next;
            p1_valid_reg   <= p1_valid_next;
            p1_src_reg     <= p1_src_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_MBC1_MODE: mbc1_mode_reg <= cfg_data[0];
                    CFG_ROM_BYTES: rom_bytes_reg <= cfg_data;
                    CFG_RAM_BYTES: ram_bytes_reg <= cfg_data[RAM_LEN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

/* rtl/core/cbc_checker.sv */
`timescale 1ns / 1ps
// Port checker for the cartridge bank controller, bound to the top level.
// Depends on cbc_pkg and cartridge_bank_controller.
module cbc_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [cbc_pkg::OP_W-1:0]   s_tuser,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [cbc_pkg::BYTE_W-1:0] m_tdata
);
    import cbc_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Drop a result only after its transfer
    a_out_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_tvalid) |-> $past(m_tready))
        else $error("result dropped without transfer");

    // Block input while the RAM clearing sweep starts
    a_clear_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_tready)
        else $error("input taken during RAM clearing");

    // Every read transfer yields a result
    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready
        && (s_tuser == OP_ROM_READ || s_tuser == OP_RAM_READ) |-> ##2 m_tvalid)
        else $error("read produced no result");

endmodule

bind cartridge_bank_controller cbc_checker u_cbc_checker (.*);

/* sim/cbc_read_check.sv */
`timescale 1ns / 1ps
// Read-byte checker for the cartridge bank controller: watches every channel,
// keeps its own copy of the mapper state and compares each read result.
// Depends on cbc_pkg.
module cbc_read_check #(
    parameter int ROM_BYTES = 65536,
    parameter int RAM_BYTES = 32768
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [cbc_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [cbc_pkg::OP_W-1:0]       s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [cbc_pkg::BYTE_W-1:0]     m_tdata,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             pending,
    output int                             failures
);
    import cbc_pkg::*;

    localparam int BANK_SPAN = 'h4000;
    localparam int RAM_SPAN  = 'h2000;

    // Mapper state as the block should hold it
    logic [7:0]            rom_image [0:ROM_BYTES-1];
    logic [7:0]            ram_image [0:RAM_BYTES-1];
    logic [ROM_BANK_W-1:0] rom_bank_q;
    logic [RAM_BANK_W-1:0] ram_bank_q;
    logic                  ram_on;
    logic                  mode_q;
    int                    rom_len_q;
    int                    ram_len_q;

    // Read bytes still owed by the block, oldest first
    logic [7:0] read_bytes_due [$];

    logic [15:0] addr;
    logic [15:0] idx;
    logic [7:0]  wbyte;
    logic [7:0]  due;
    int          banked;
    int          slot;

    // Offset into the RAM store, or -1 when the access maps to nothing
    function automatic int ram_slot(input logic [15:0] a);
        int off;
        if (!ram_on || ram_len_q == 0 || a[15:13] != RAM_WINDOW) return -1;
        off = int'(ram_bank_q) * RAM_SPAN + int'(a[12:0]);
        if (off >= ram_len_q || off >= RAM_BYTES) return -1;
        return off;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RAM_BYTES; i++) ram_image[i] = 8'h00;
            rom_bank_q = ROM_BANK_ONE;
            ram_bank_q = '0;
            ram_on     = 1'b0;
            mode_q     = 1'b0;
            rom_len_q  = 32768;
            ram_len_q  = 0;
            read_bytes_due.delete();
        end else begin
            // Compare a result transfer with the oldest owed byte
            if (m_tvalid && m_tready) begin
                if (read_bytes_due.size() == 0) begin
                    $error("read_data: expected none, actual %h", m_tdata);
                    failures++;
                end else begin
                    due = read_bytes_due.pop_front();
                    if (m_tdata !== due) begin
                        $error("read_data: expected %h, actual %h", due, m_tdata);
                        failures++;
                    end
                end
            end

            // Track register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MBC1_MODE: mode_q = cfg_data[0];
                    CFG_ROM_BYTES: rom_len_q = int'(cfg_data);
                    CFG_RAM_BYTES: ram_len_q = int'(cfg_data[15:0]);
                    default: ;
                endcase
            end

            // Advance the mapper by one bus access
            if (s_tvalid && s_tready) begin
                addr  = s_tdata[15:0];
                idx   = s_tdata[31:16];
                wbyte = s_tdata[39:32];
                case (s_tuser)
                    OP_ROM_READ: begin
                        due = OPEN_BUS;
                        if (addr[15:14] == ROM_FIXED_WIN) begin
                            due = rom_image[addr];
                        end else if (addr[15:14] == ROM_BANK_WIN) begin
                            banked = int'(rom_bank_q) * BANK_SPAN + int'(addr[13:0]);
                            if (banked < rom_len_q && banked < ROM_BYTES)
                                due = rom_image[banked];
                        end
                        read_bytes_due.push_back(due);
                    end
                    OP_CTRL_WRITE: begin
                        // 0x6000 and up are not decoded
                        if (mode_q) begin
                            case (addr[15:13])
                                REG_RAM_ENABLE: ram_on = (wbyte[3:0] == RAM_ENABLE_KEY);
                                REG_ROM_BANK:
                                    rom_bank_q = (wbyte[4:0] == '0) ? ROM_BANK_ONE
                                                                    : wbyte[4:0];
                                REG_RAM_BANK_L: ram_bank_q = wbyte[1:0];
                                default: ;
                            endcase
                        end
                    end
                    OP_RAM_READ: begin
                        slot = ram_slot(addr);
                        read_bytes_due.push_back(slot < 0 ? OPEN_BUS : ram_image[slot]);
                    end
                    OP_RAM_WRITE: begin
                        slot = ram_slot(addr);
                        if (slot >= 0) ram_image[slot] = wbyte;
                    end
                    OP_ROM_LOAD: begin
                        if (int'(idx) < ROM_BYTES) rom_image[idx] = wbyte;
                    end
                    default: ;
                endcase
            end
        end
        pending = read_bytes_due.size();
    end

endmodule

/* sim/cartridge_bank_controller_test.sv */
`timescale 1ns / 1ps
// Top of the cartridge bank controller testbench: clock, reset, stimulus,
// result back-pressure and the verdict. Depends on cbc_pkg, the block and cbc_read_check.
module cartridge_bank_controller_test;
    import cbc_pkg::*;

    localparam int ROM_BYTES    = 65536;
    localparam int RAM_BYTES    = 32768;
    localparam int LIMIT        = 400000;
    localparam int STALL_CYCLES = 300;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 265;
    localparam int DRAIN_CYCLES = 8;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [BYTE_W-1:0]     m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int pending;
    int failures;
    int cycles = 0;

    // Idling control shared by sender and receiver
    bit quiet = 1'b0;
    int stall_asks = 0;
    int stall_seen = 0;
    int stall_left = 0;

    // What the stimulus must know to keep ROM reads on loaded bytes
    bit rom_loaded [0:ROM_BYTES-1];
    int loaded_list [$];
    bit mbc1_sh;
    int rom_len_sh;
    int rom_bank_sh;

    cartridge_bank_controller #(
        .ROM_BYTES(ROM_BYTES),
        .RAM_BYTES(RAM_BYTES)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    cbc_read_check #(
        .ROM_BYTES(ROM_BYTES),
        .RAM_BYTES(RAM_BYTES)
    ) read_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pending(pending), .failures(failures)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Give up on a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: random back-pressure plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_asks != stall_seen) begin
                stall_seen = stall_asks;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet || ($urandom_range(0, 99) >= 12);
            end
        end
    end

    // Offer one access and hold it until the transfer; leaves s_tvalid high
    task automatic send_item(input logic [2:0] op, input logic [15:0] addr,
                             input logic [15:0] idx, input logic [7:0] data);
        if (!quiet && $urandom_range(0, 99) < 12) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {data, idx, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (op == OP_CTRL_WRITE && mbc1_sh && addr[15:13] == REG_ROM_BANK)
            rom_bank_sh = (data[4:0] == '0) ? 1 : int'(data[4:0]);
        if (op == OP_ROM_LOAD && !rom_loaded[idx]) begin
            rom_loaded[idx] = 1'b1;
            loaded_list.push_back(int'(idx));
        end
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic apply_config(input bit mode, input int rom_len, input int ram_len);
        cfg_write(CFG_MBC1_MODE, CFG_DATA_W'(mode));
        cfg_write(CFG_ROM_BYTES, CFG_DATA_W'(rom_len));
        cfg_write(CFG_RAM_BYTES, CFG_DATA_W'(ram_len));
        cfg_valid  <= 1'b0;
        mbc1_sh    = mode;
        rom_len_sh = rom_len;
    endtask

    // Pause the sender until every owed result is out, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // A ROM read must never touch a byte no load has written
    function automatic bit rom_addr_safe(input logic [15:0] a);
        int banked;
        if (a[15]) return 1'b1;
        if (!a[14]) return rom_loaded[a];
        banked = rom_bank_sh * 'h4000 + int'(a[13:0]);
        if (banked >= rom_len_sh || banked >= ROM_BYTES) return 1'b1;
        return rom_loaded[banked];
    endfunction

    function automatic logic [15:0] rom_read_address();
        logic [15:0] a;
        int i;
        repeat (8) begin
            if ($urandom_range(0, 9) < 6 && loaded_list.size() > 0) begin
                i = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                a = (i < 'h4000) ? 16'(i) : (16'h4000 | 16'(i & 'h3FFF));
            end else begin
                a = 16'($urandom_range(0, 'hFFFF));
            end
            if (rom_addr_safe(a)) return a;
        end
        return 16'h8000 | 16'($urandom_range(0, 'h7FFF));
    endfunction

    // Mostly inside the RAM window, often on a few hot bytes
    function automatic logic [15:0] pick_ram_addr();
        int k;
        k = $urandom_range(0, 19);
        if (k < 9) return 16'hA000 | 16'($urandom_range(0, 15));
        if (k < 17) return 16'hA000 | 16'($urandom_range(0, 'h1FFF));
        return 16'($urandom_range(0, 'hFFFF));
    endfunction

    task automatic random_item();
        int r;
        logic [2:0]  op;
        logic [15:0] addr;
        logic [15:0] idx;
        logic [7:0]  data;
        r    = $urandom_range(0, 99);
        addr = 16'($urandom_range(0, 'hFFFF));
        idx  = 16'($urandom_range(0, 'hFFFF));
        data = 8'($urandom_range(0, 'hFF));
        if (r < 28) begin
            op   = OP_ROM_READ;
            addr = rom_read_address();
        end else if (r < 43) begin
            op = OP_CTRL_WRITE;
            case ($urandom_range(0, 3))
                0: begin
                    addr = 16'($urandom_range(0, 'h1FFF));
                    if ($urandom_range(0, 3) != 0) data[3:0] = RAM_ENABLE_KEY;
                end
                1: begin
                    // keep the bank mostly where loaded bytes can be seen
                    addr = 16'($urandom_range('h2000, 'h3FFF));
                    if ($urandom_range(0, 4) < 3) data[4:0] = 5'($urandom_range(0, 3));
                end
                2: addr = 16'($urandom_range('h4000, 'h5FFF));
                default: ;
            endcase
        end else if (r < 65) begin
            op   = OP_RAM_READ;
            addr = pick_ram_addr();
        end else if (r < 83) begin
            op   = OP_RAM_WRITE;
            addr = pick_ram_addr();
        end else if (r < 96) begin
            op = OP_ROM_LOAD;
        end else begin
            op = 3'($urandom_range(5, 7));
        end
        send_item(op, addr, idx, data);
    endtask

    initial begin
        bit mode;
        int rom_len;
        int ram_len;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_ROM_READ;
        cfg_valid = 1'b0;
        cfg_index = CFG_MBC1_MODE;
        cfg_data  = '0;
        mbc1_sh     = 1'b0;
        rom_len_sh  = 32768;
        rom_bank_sh = 1;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Registers are taken while the RAM is still being cleared
        apply_config(1'b1, 65536, 32768);

        // Directed: window edges, bank zero, masking, RAM enable and banking
        send_item(OP_ROM_LOAD, 16'h0000, 16'h0000, 8'h5A);
        send_item(OP_ROM_LOAD, 16'hFFFF, 16'h3FFF, 8'hA5);
        send_item(OP_ROM_LOAD, 16'h0000, 16'h4000, 8'h11);
        send_item(OP_ROM_LOAD, 16'h0000, 16'h7FFF, 8'h77);
        send_item(OP_ROM_LOAD, 16'h0000, 16'hFFFF, 8'hEE);
        send_item(OP_ROM_READ, 16'h0000, 16'h0000, 8'h00);
        send_item(OP_ROM_READ, 16'h3FFF, 16'hFFFF, 8'hFF);
        send_item(OP_ROM_READ, 16'h4000, 16'h0000, 8'h00);
        send_item(OP_ROM_READ, 16'h7FFF, 16'h0000, 8'h00);
        send_item(OP_ROM_READ, 16'h8000, 16'h0000, 8'h00);
        send_item(OP_CTRL_WRITE, 16'h3FFF, 16'h0000, 8'hE0);
        send_item(OP_ROM_READ, 16'h7FFF, 16'h0000, 8'h00);
        send_item(OP_CTRL_WRITE, 16'h2000, 16'h0000, 8'hE3);
        send_item(OP_ROM_READ, 16'h7FFF, 16'h0000, 8'h00);
        send_item(OP_CTRL_WRITE, 16'h2000, 16'h0000, 8'h1F);
        send_item(OP_ROM_READ, 16'h4000, 16'h0000, 8'h00);
        send_item(OP_RAM_READ, 16'hBFFF, 16'h0000, 8'h00);
        send_item(OP_CTRL_WRITE, 16'h1FFF, 16'h0000, 8'hFA);
        send_item(OP_CTRL_WRITE, 16'h5FFF, 16'h0000, 8'hFF);
        send_item(OP_RAM_WRITE, 16'hBFFF, 16'h0000, 8'h99);
        send_item(OP_RAM_READ, 16'hBFFF, 16'h0000, 8'h00);
        send_item(OP_CTRL_WRITE, 16'h6000, 16'h0000, 8'h00);
        send_item(OP_RAM_READ, 16'hBFFF, 16'h0000, 8'h00);
        send_item(OP_RAM_READ, 16'hC000, 16'h0000, 8'h00);
        send_item(3'd7, 16'hFFFF, 16'hFFFF, 8'hFF);

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0: begin mode = 1'b1; rom_len = 32768; ram_len = 2048;  end
                1: begin mode = 1'b1; rom_len = 65536; ram_len = 32768; end
                2: begin mode = 1'b0; rom_len = 65536; ram_len = 8192;  end
                3: begin mode = 1'b1; rom_len = 49152; ram_len = 0;     end
                4: begin
                    mode    = 1'b1;
                    rom_len = $urandom_range(32768, 65536);
                    ram_len = $urandom_range(0, 32768);
                end
                default: begin mode = 1'b1; rom_len = 40960; ram_len = 24576; end
            endcase
            apply_config(mode, rom_len, ram_len);
            quiet = (p == 2);
            if (p == 3) stall_asks++;
            repeat (PHASE_ITEMS) random_item();
        end
        quiet = 1'b0;
        wait_idle();

        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
